// ===== design/avci_pkg.sv =====
// Shared types, constants and widths for the agent velocity clamp and integrate block
`timescale 1ns / 1ps
package avci_pkg;

  localparam int FracBitsDefault = 16;

  // Configuration register indexes
  localparam logic [2:0] RegMaxAccel = 3'd0;
  localparam logic [2:0] RegMaxSpeed = 3'd1;
  localparam logic [2:0] RegScaleX   = 3'd2;
  localparam logic [2:0] RegScaleY   = 3'd3;
  localparam logic [2:0] RegScaleZ   = 3'd4;
  localparam logic [2:0] RegDeadZone = 3'd5;

  localparam logic [30:0] MaxAccelReset = 31'd65536;
  localparam logic [30:0] MaxSpeedReset = 31'd655360;
  localparam logic [16:0] ScaleReset    = 17'd65536;
  localparam logic [30:0] DeadZoneReset = 31'd6554;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_SQ_ST,
    ST_ROOT_ST,
    ST_DIV_ST,
    ST_ADD_SCALE,
    ST_SQ_V,
    ST_ROOT_V,
    ST_DIV_V,
    ST_DEAD,
    ST_OUT
  } avci_state_t;

  // Requests to the shared square root / divide unit
  typedef struct packed {
    logic        start_sqrt;
    logic        start_div;
    logic [65:0] radicand;
    logic [62:0] dividend;
    logic [31:0] divisor;
  } avci_iter_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] result;
  } avci_iter_rsp_t;

endpackage

// ===== design/agent_velocity_clamp_integrate_top.sv =====
// Top level: configuration, state, sequencer and output register of the agent update
`timescale 1ns / 1ps
// Agent velocity clamp and integrate.
// The s_axis channel carries one tick for one agent: steering vector, time step
// and alive flag. After the update the m_axis channel carries the new position
// and velocity, all Q16.16. One result leaves for every item taken.
// Configuration is written through cfg_we / cfg_addr / cfg_data while idle;
// unknown indexes are ignored.
// Timing: a frozen agent's result is offered in the cycle after acceptance. A
// live agent uses one shared multiplier (15 products, one a cycle) and one
// bit-serial unit for square root and for division, which runs once per axis.
// Each active clamp adds one square root and three divisions to the item, so
// an item with both clamps active is the longest.
// s_axis_tready is low from acceptance until the result is taken, so one item
// is in flight. A stalled receiver holds the result in the output register.
// Reset clears position, velocity and the sequencer and loads the register
// defaults.
module agent_velocity_clamp_integrate_top
  import avci_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // steer_x [31:0], steer_y [63:32], steer_z [95:64], time_step [111:96]
  input  logic [111:0] s_axis_tdata,
  // is_alive
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, 32 bits each from bit 0
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_data
);

  logic [30:0] max_accel, max_speed, dead_zone;
  logic [16:0] scale [3];

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] vec [3];
  logic [15:0]        dt;
  logic [65:0]        acc;
  logic [32:0]        len;
  logic [30:0]        lim;
  logic [2:0]         step;
  logic               waiting;

  avci_state_t        state, state_next;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  avci_iter_req_t     ireq;
  avci_iter_rsp_t     irsp;

  avci_mac u_mac (.clk(clk), .a(ma), .b(mb), .p(mp));
  avci_iter u_iter (.clk(clk), .rst(rst), .req(ireq), .rsp(irsp));

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  logic signed [65:0] shifted;
  logic [1:0]         ax;
  logic [65:0]        lim_sq;

  // Spare step after the last axis reads axis 0; its product is never used
  assign ax      = (step[1:0] == 2'd3) ? 2'd0 : step[1:0];
  assign shifted = mp >>> FRAC_BITS;
  assign lim_sq  = {35'd0, lim} * {35'd0, lim};

  // Select multiplier operands per state and step
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_POS: begin
        ma = 33'(vel[ax]);
        mb = {17'd0, dt};
      end
      ST_SQ_ST, ST_SQ_V, ST_DEAD: begin
        ma = 33'(vec[ax]);
        mb = 33'(vec[ax]);
      end
      ST_ADD_SCALE: begin
        ma = 33'(sat32(66'(vel[ax]) + 66'(vec[ax])));
        mb = {16'd0, scale[ax]};
      end
      default: ;
    endcase
  end

  // Shared unit requests
  always_comb begin
    ireq            = '0;
    ireq.radicand   = acc;
    ireq.dividend   = {31'd0, mag32(vec[ax])} * {32'd0, lim};
    ireq.divisor    = len[31:0];
    ireq.start_sqrt = (state == ST_ROOT_ST || state == ST_ROOT_V) && !waiting;
    ireq.start_div  = (state == ST_DIV_ST || state == ST_DIV_V) && !waiting;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_axis_tvalid) state_next = s_axis_tuser ? ST_POS : ST_OUT;
      ST_POS:       if (step == 3'd3) state_next = ST_SQ_ST;
      ST_SQ_ST:     if (step == 3'd4)
                      state_next = (acc > lim_sq) ? ST_ROOT_ST : ST_ADD_SCALE;
      ST_ROOT_ST:   if (irsp.done) state_next = ST_DIV_ST;
      ST_DIV_ST:    if (irsp.done && ax == 2'd2) state_next = ST_ADD_SCALE;
      ST_ADD_SCALE: if (step == 3'd3) state_next = ST_SQ_V;
      ST_SQ_V:      if (step == 3'd4)
                      state_next = (acc > lim_sq) ? ST_ROOT_V : ST_DEAD;
      ST_ROOT_V:    if (irsp.done) state_next = ST_DIV_V;
      ST_DIV_V:     if (irsp.done && ax == 2'd2) state_next = ST_DEAD;
      ST_DEAD:      if (step == 3'd4) state_next = ST_OUT;
      ST_OUT:       if (m_axis_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel <= MaxAccelReset;
      max_speed <= MaxSpeedReset;
      scale[0]  <= ScaleReset;
      scale[1]  <= ScaleReset;
      scale[2]  <= ScaleReset;
      dead_zone <= DeadZoneReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegMaxAccel: max_accel <= cfg_data;
        RegMaxSpeed: max_speed <= cfg_data;
        RegScaleX:   scale[0]  <= cfg_data[16:0];
        RegScaleY:   scale[1]  <= cfg_data[16:0];
        RegScaleZ:   scale[2]  <= cfg_data[16:0];
        RegDeadZone: dead_zone <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath: products land in the cycle after issue, so step counts to 3 or 4
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
      step    <= '0;
      waiting <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (s_axis_tvalid) begin
            vec[0] <= s_axis_tdata[31:0];
            vec[1] <= s_axis_tdata[63:32];
            vec[2] <= s_axis_tdata[95:64];
            dt     <= s_axis_tdata[111:96];
            lim    <= max_accel;
            if (!s_axis_tuser) begin
              for (int i = 0; i < 3; i++) vel[i] <= '0;
            end
          end
        end
        ST_POS: begin
          if (step != 3'd0) pos[2'(step - 3'd1)] <= sat32(66'(pos[2'(step - 3'd1)]) + shifted);
          step <= (step == 3'd3) ? 3'd0 : step + 3'd1;
        end
        ST_SQ_ST, ST_SQ_V, ST_DEAD: begin
          // Sum the three squares; the first one starts the sum
          if (step == 3'd1) acc <= mp;
          else if (step == 3'd2 || step == 3'd3) acc <= acc + mp;
          if (state == ST_DEAD && step == 3'd0) lim <= dead_zone;
          // Snap to zero below the dead zone, else keep the new velocity
          if (state == ST_DEAD && step == 3'd4) begin
            for (int i = 0; i < 3; i++) vel[i] <= (acc < lim_sq) ? 32'sd0 : vec[i];
          end
          step <= (step == 3'd4) ? 3'd0 : step + 3'd1;
        end
        ST_ROOT_ST, ST_ROOT_V: begin
          waiting <= !irsp.done;
          if (irsp.done) len <= irsp.result;
        end
        ST_DIV_ST, ST_DIV_V: begin
          waiting <= !irsp.done;
          if (irsp.done) begin
            vec[ax] <= vec[ax][31] ? 32'(-irsp.result[31:0]) : irsp.result[31:0];
            step    <= (ax == 2'd2) ? 3'd0 : step + 3'd1;
          end
        end
        ST_ADD_SCALE: begin
          if (step != 3'd0) vec[2'(step - 3'd1)] <= sat32(shifted);
          if (step == 3'd3) lim <= max_speed;
          step <= (step == 3'd3) ? 3'd0 : step + 3'd1;
        end
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};

endmodule

// ===== design/avci_iter.sv =====
// Shared bit-serial unit: integer square root and unsigned division, one bit a cycle
`timescale 1ns / 1ps
module avci_iter
  import avci_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  avci_iter_req_t req,
  output avci_iter_rsp_t rsp
);

  logic        busy;
  logic        is_div;
  logic [6:0]  count;
  logic [65:0] num;
  logic [67:0] rem;
  logic [34:0] root;
  logic [62:0] quo;
  logic [31:0] den;
  logic        done;

  logic [67:0] trial;
  logic [67:0] rem_shift;
  logic [32:0] drem_shift;
  logic [32:0] ddiff;

  // Trial values for one step of each operation
  always_comb begin
    rem_shift  = {rem[65:0], num[65:64]};
    trial      = {31'd0, root, 2'b01};
    drem_shift = {rem[31:0], quo[62]};
    ddiff      = drem_shift - {1'b0, den};
  end

  // Advance one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start_sqrt) begin
        busy   <= 1'b1;
        is_div <= 1'b0;
        count  <= 7'd33;
        num    <= req.radicand;
        rem    <= '0;
        root   <= '0;
      end else if (req.start_div) begin
        busy   <= 1'b1;
        is_div <= 1'b1;
        count  <= 7'd63;
        quo    <= req.dividend;
        den    <= req.divisor;
        rem    <= '0;
      end else if (busy) begin
        if (is_div) begin
          if (!ddiff[32]) begin
            rem <= {36'd0, ddiff[31:0]};
            quo <= {quo[61:0], 1'b1};
          end else begin
            rem <= {35'd0, drem_shift};
            quo <= {quo[61:0], 1'b0};
          end
        end else begin
          num <= {num[63:0], 2'b00};
          if (rem_shift >= trial) begin
            rem  <= rem_shift - trial;
            root <= {root[33:0], 1'b1};
          end else begin
            rem  <= rem_shift;
            root <= {root[33:0], 1'b0};
          end
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = is_div ? quo[32:0] : root[32:0];

endmodule

// ===== design/avci_mac.sv =====
// Shared signed multiplier with a registered product
`timescale 1ns / 1ps
module avci_mac (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  // Register each product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== bench/avci_checker.sv =====
// Checker for the agent update: watches the channels, predicts each result and compares
`timescale 1ns / 1ps
module avci_checker
  import avci_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [191:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam int Frac = FracBitsDefault;

  // Agent state and register copy
  logic signed [31:0] agent_pos [3];
  logic signed [31:0] agent_vel [3];
  logic [30:0]        accel_limit;
  logic [30:0]        speed_limit;
  logic [30:0]        dead_speed;
  logic [16:0]        axis_scale [3];

  // Vector under clamp, 64-bit signed components
  longint             work_vec [3];

  // Predicted results in order, held in a small ring
  logic [191:0]       expected_updates [16];
  logic [3:0]         head_idx;
  logic [3:0]         tail_idx;
  int                 held;

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] work_len_sq();
    logic [63:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s += magnitude(work_vec[i]) * magnitude(work_vec[i]);
    return s;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Shrink the working vector to the given length, components truncated toward zero
  task automatic clamp_work(input logic [63:0] limit);
    logic [63:0] s;
    logic [63:0] len;
    logic [63:0] q;
    s = work_len_sq();
    if (s > limit * limit) begin
      len = floor_sqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = magnitude(work_vec[i]) * limit / len;
        work_vec[i] = (work_vec[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endtask

  // Advance the agent by one tick and return the packed position and velocity
  task automatic predict_update(input logic [111:0] tick, input logic alive,
                                output logic [191:0] upd);
    logic [15:0] dt;
    longint      d;
    longint      t;
    dt = tick[111:96];
    if (!alive) begin
      for (int i = 0; i < 3; i++) agent_vel[i] = '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        d = (longint'(agent_vel[i]) * longint'({48'd0, dt})) >>> Frac;
        agent_pos[i] = sat32(longint'(agent_pos[i]) + d);
        work_vec[i] = longint'($signed(tick[32*i +: 32]));
      end
      clamp_work({33'd0, accel_limit});
      for (int i = 0; i < 3; i++) begin
        t = longint'(sat32(longint'(agent_vel[i]) + work_vec[i]));
        work_vec[i] = longint'(sat32((t * longint'({47'd0, axis_scale[i]})) >>> Frac));
      end
      clamp_work({33'd0, speed_limit});
      if (work_len_sq() < {33'd0, dead_speed} * {33'd0, dead_speed}) begin
        for (int i = 0; i < 3; i++) work_vec[i] = 0;
      end
      for (int i = 0; i < 3; i++) agent_vel[i] = sat32(work_vec[i]);
    end
    upd = {agent_vel[2], agent_vel[1], agent_vel[0], agent_pos[2], agent_pos[1], agent_pos[0]};
  endtask

  always @(posedge clk) begin
    logic [191:0] want;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        agent_pos[i] = '0;
        agent_vel[i] = '0;
        axis_scale[i] = ScaleReset;
      end
      accel_limit = MaxAccelReset;
      speed_limit = MaxSpeedReset;
      dead_speed  = DeadZoneReset;
      head_idx = '0;
      tail_idx = '0;
      held = 0;
      fail_count = 0;
    end else begin
      // Register writes; unknown indexes drop out
      if (cfg_we) begin
        case (cfg_addr)
          RegMaxAccel: accel_limit = cfg_data;
          RegMaxSpeed: speed_limit = cfg_data;
          RegScaleX:   axis_scale[0] = cfg_data[16:0];
          RegScaleY:   axis_scale[1] = cfg_data[16:0];
          RegScaleZ:   axis_scale[2] = cfg_data[16:0];
          RegDeadZone: dead_speed = cfg_data;
          default: ;
        endcase
      end
      // Compare each result transaction with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (held == 0) begin
          $display("%0t: expected no result, actual %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_updates[head_idx];
          head_idx++;
          held--;
          for (int f = 0; f < 6; f++) begin
            if (want[32*f +: 32] !== m_axis_tdata[32*f +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want[32*f +: 32], m_axis_tdata[32*f +: 32]);
              fail_count++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_update(s_axis_tdata, s_axis_tuser, want);
        expected_updates[tail_idx] = want;
        tail_idx++;
        held++;
      end
    end
    pending = held;
  end

endmodule

// ===== bench/agent_velocity_clamp_integrate_top_test.sv =====
// Testbench top: clock, reset, stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module agent_velocity_clamp_integrate_top_test;
  import avci_pkg::*;

  localparam logic [2:0] RegSpareLow  = 3'd6;
  localparam logic [2:0] RegSpareHigh = 3'd7;
  localparam int         CycleLimit   = 4000000;
  localparam int         Phases       = 8;
  localparam int         PhaseItems   = 215;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [30:0]  cfg_data;
  int           fail_count;
  int           pending;
  int           cycles;
  bit           gaps_on;

  agent_velocity_clamp_integrate_top dut (.*);

  avci_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop on a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: ready with random stall bursts while gaps are on
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // One write, then write enable is dropped again before the task returns
  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_tick(input logic [31:0] sx, input logic [31:0] sy,
                           input logic [31:0] sz, input logic [15:0] dt,
                           input logic alive);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, sz, sy, sx};
    s_axis_tuser  <= alive;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly modest steering so the clamps bite at varied limits, some full range
  function automatic logic [31:0] rand_steer();
    logic [31:0] m;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: m = $urandom_range(0, 32'h00FFFFFF);
      default: m = $urandom_range(0, 32'h0003FFFF);
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [15:0] rand_dt();
    return $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4096));
  endfunction

  function automatic logic [30:0] rand_limit();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 32'h000FFFFF));
      default: return 31'($urandom_range(0, 32'h00FFFFFF));
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    gaps_on  = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, frozen agent, time step extremes
    send_tick(32'h0, 32'h0, 32'h0, 16'h0, 1'b1);
    send_tick(32'h7FFFFFFF, 32'h0, 32'h0, 16'hFFFF, 1'b1);
    send_tick(32'h80000000, 32'h80000000, 32'h80000000, 16'hFFFF, 1'b1);
    send_tick(32'h00008000, 32'hFFFF8000, 32'h00001000, 16'h8000, 1'b1);
    send_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0);
    send_tick(32'h00000100, 32'h0, 32'h0, 16'h0001, 1'b1);
    drain();
    // Scale above one, loose limits: saturate position and velocity
    write_reg(RegMaxAccel, 31'h7FFFFFFF);
    write_reg(RegMaxSpeed, 31'h7FFFFFFF);
    write_reg(RegScaleX, 31'h1FFFF);
    write_reg(RegScaleY, 31'h1FFFF);
    write_reg(RegScaleZ, 31'h0);
    write_reg(RegDeadZone, 31'h0);
    write_reg(RegSpareLow, 31'h0);
    write_reg(RegSpareHigh, 31'h7FFFFFFF);
    repeat (4) send_tick(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 1'b1);
    send_tick(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1);
    send_tick(32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0);
    drain();
    // Zero limits: no steering, velocity forced to zero
    write_reg(RegMaxAccel, 31'h0);
    write_reg(RegMaxSpeed, 31'h0);
    send_tick(32'h00050000, 32'h00030000, 32'hFFFE0000, 16'h4000, 1'b1);
    send_tick(32'h80000000, 32'h7FFFFFFF, 32'h1, 16'hFFFF, 1'b1);
    drain();
    // Huge dead zone swallows every velocity
    write_reg(RegMaxAccel, 31'h00100000);
    write_reg(RegMaxSpeed, 31'h00400000);
    write_reg(RegDeadZone, 31'h7FFFFFFF);
    send_tick(32'h00050000, 32'hFFF00000, 32'h00020000, 16'h2000, 1'b1);
    send_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b1);
    drain();

    // Random phases, each with its own register setting
    gaps_on = 1'b1;
    for (int p = 0; p < Phases; p++) begin
      if (p == Phases - 1) gaps_on = 1'b0;
      write_reg(RegMaxAccel, p == 0 ? 31'h7FFFFFFF : rand_limit());
      write_reg(RegMaxSpeed, p == 0 ? 31'h7FFFFFFF : rand_limit());
      write_reg(RegScaleX, p == 1 ? 31'h1FFFF : 31'($urandom_range(0, 32'h1FFFF)));
      write_reg(RegScaleY, p == 1 ? 31'h0 : 31'($urandom_range(32'hC000, 32'h10000)));
      write_reg(RegScaleZ, 31'($urandom_range(0, 32'h1FFFF)));
      write_reg(RegDeadZone, p == 2 ? 31'h0 : 31'($urandom_range(0, 32'h00020000)));
      for (int n = 0; n < PhaseItems; n++) begin
        send_tick(rand_steer(), rand_steer(), rand_steer(), rand_dt(),
                  $urandom_range(0, 9) != 0);
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== agent_velocity_clamp_integrate_top.f =====
design/avci_pkg.sv
design/avci_iter.sv
design/avci_mac.sv
design/agent_velocity_clamp_integrate_top.sv
bench/avci_checker.sv
bench/agent_velocity_clamp_integrate_top_test.sv
